/* hw/rtl/gbps_pkg.sv */
package gbps_pkg;

    // Fixed geometry and scaling of the shader
    localparam int FIX_SCALE     = 65536;
    localparam int BOX_WIDTH     = 16;
    localparam int BOX_HEIGHT    = 12;
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    localparam int LIGHT_W   = 32;
    localparam int FIX_SHIFT = $clog2(FIX_SCALE);
    localparam int INT_W     = LIGHT_W - FIX_SHIFT;
    // BOX_WIDTH and FIX_SCALE are powers of two
    localparam int COL_SHIFT       = $clog2(BOX_WIDTH);
    localparam int COL_SCALE_SHIFT = $clog2(FIX_SCALE / BOX_WIDTH);
    localparam int COL_W           = $clog2(BOX_WIDTH);
    localparam int ROW_W           = $clog2(BOX_HEIGHT);
    localparam int BRIGHT_MAX      = 31;

    // Width of |corner difference| * FIX_SCALE / BOX_HEIGHT
    localparam int STEP_W = $clog2((255 * FIX_SCALE) / BOX_HEIGHT + 1);

    typedef enum logic {
        OP_START = 1'b0,
        OP_PIXEL = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [10:0]       box_x;
        logic signed [9:0]        box_y;
        logic signed [7:0]        light_tl;
        logic signed [7:0]        light_tr;
        logic                     transparent;
        logic [7:0]               src;
        logic [LIGHT_W-1:0]       lstep;
        logic [LIGHT_W-1:0]       rstep;
        logic [LIGHT_W-1:0]       cstep0;
    } t_cmd;

    typedef struct packed {
        logic             done;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_back_status;

    typedef logic [STEP_W-1:0] t_step_tab [0:255];

    function automatic t_step_tab build_step_tab();
        t_step_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = STEP_W'((i * FIX_SCALE) / BOX_HEIGHT);
        end
        return tab;
    endfunction

    // Row step magnitude for each |bottom - top| corner difference
    localparam t_step_tab STEP_TAB = build_step_tab();

endpackage

/* hw/rtl/gbps_front.sv */
module gbps_front import gbps_pkg::*; (
    input  logic              i_push,
    input  logic              i_full,
    input  logic              i_operation,
    input  logic signed [10:0] i_box_x,
    input  logic signed [9:0] i_box_y,
    input  logic signed [7:0] i_light_top_left,
    input  logic signed [7:0] i_light_top_right,
    input  logic signed [7:0] i_light_bottom_left,
    input  logic signed [7:0] i_light_bottom_right,
    input  logic              i_transparent,
    input  logic [7:0]        i_src_pixel,
    output logic              o_wr,
    output t_cmd              o_cmd
);

    logic signed [8:0]         d_left;
    logic signed [8:0]         d_right;
    logic signed [LIGHT_W-1:0] top_diff;

    // Divide a corner difference times FIX_SCALE by the box height, towards zero
    function automatic logic [LIGHT_W-1:0] row_step(input logic signed [8:0] d);
        logic [8:0]         mag;
        logic [LIGHT_W-1:0] q;
        mag = d[8] ? 9'(-d) : 9'(d);
        q   = LIGHT_W'(STEP_TAB[mag[7:0]]);
        return d[8] ? LIGHT_W'(-q) : q;
    endfunction

    always_comb begin
        d_left   = 9'(i_light_bottom_left) - 9'(i_light_top_left);
        d_right  = 9'(i_light_bottom_right) - 9'(i_light_top_right);
        top_diff = LIGHT_W'(9'(i_light_top_right) - 9'(i_light_top_left));

        o_wr               = i_push && !i_full;
        o_cmd.op           = t_op'(i_operation);
        o_cmd.box_x        = i_box_x;
        o_cmd.box_y        = i_box_y;
        o_cmd.light_tl     = i_light_top_left;
        o_cmd.light_tr     = i_light_top_right;
        o_cmd.transparent  = i_transparent;
        o_cmd.src          = i_src_pixel;
        o_cmd.lstep        = row_step(d_left);
        o_cmd.rstep        = row_step(d_right);
        // First row: (right - left) * FIX_SCALE / BOX_WIDTH is exact
        o_cmd.cstep0       = LIGHT_W'(top_diff <<< COL_SCALE_SHIFT);
    end

endmodule

/* hw/rtl/gbps_queue.sv */
module gbps_queue import gbps_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_data,
    input  logic i_rd,
    output t_cmd o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

/* hw/rtl/gbps_back.sv */
module gbps_back import gbps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_take,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [7:0]         o_out_pixel,
    output logic signed [10:0] o_screen_x,
    output logic signed [9:0]  o_screen_y,
    output logic               o_write_enable,
    output logic               o_last_of_box,
    output t_back_status       o_status
);

    localparam logic signed [11:0] SX_LIMIT = 12'(SCREEN_WIDTH);
    localparam logic signed [10:0] SY_LAST  = 11'(SCREEN_HEIGHT - 1);

    // Box state
    logic [LIGHT_W-1:0] r_left, n_left;
    logic [LIGHT_W-1:0] r_right, n_right;
    logic [LIGHT_W-1:0] r_left_nx, n_left_nx;
    logic [LIGHT_W-1:0] r_right_nx, n_right_nx;
    logic [LIGHT_W-1:0] r_lstep, n_lstep;
    logic [LIGHT_W-1:0] r_rstep, n_rstep;
    logic [LIGHT_W-1:0] r_cstep, n_cstep;
    logic [LIGHT_W-1:0] r_cstep_nx, n_cstep_nx;
    logic [LIGHT_W-1:0] r_run, n_run;
    logic signed [10:0] r_ox, n_ox;
    logic signed [9:0]  r_oy, n_oy;
    logic               r_skip, n_skip;
    logic               r_done, n_done;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;

    // Result register
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_pixel, n_out_pixel;
    logic signed [10:0] r_screen_x, n_screen_x;
    logic signed [9:0]  r_screen_y, n_screen_y;
    logic               r_we, n_we;
    logic               r_last, n_last;

    logic                     is_start;
    logic                     produce;
    logic                     out_free;
    logic                     take;
    logic                     col_last;
    logic [LIGHT_W-1:0]       light;
    logic                     round_up;
    logic signed [INT_W:0]    lvl;
    logic signed [INT_W+1:0]  bright_sum;
    logic [4:0]               bright;
    logic signed [11:0]       sx;
    logic signed [10:0]       sy;
    logic signed [LIGHT_W:0]  cdiff;
    logic signed [LIGHT_W:0]  cbias;
    logic [LIGHT_W-1:0]       left0;
    logic [LIGHT_W-1:0]       right0;

    always_comb begin
        is_start = (i_cmd.op == OP_START);
        produce  = i_cmd_valid && !is_start && !r_done;
        out_free = !r_out_valid || i_pop;
        take     = i_cmd_valid && (!produce || out_free);
        col_last = (r_col == COL_W'(BOX_WIDTH - 1));

        // Light of this pixel and its integer part, truncated towards zero
        light      = (r_col == '0) ? r_left : r_run;
        round_up   = light[LIGHT_W-1] && (|light[FIX_SHIFT-1:0]);
        lvl        = {light[LIGHT_W-1], light[LIGHT_W-1:FIX_SHIFT]}
                   + {{INT_W{1'b0}}, round_up};
        bright_sum = {lvl[INT_W], lvl} + {{(INT_W - 3){1'b0}}, i_cmd.src[4:0]};
        priority if (bright_sum[INT_W+1]) begin
            bright = '0;
        end else if (|bright_sum[INT_W:5]) begin
            bright = 5'(BRIGHT_MAX);
        end else begin
            bright = bright_sum[4:0];
        end

        sx = {r_ox[10], r_ox} + {{(12 - COL_W){1'b0}}, r_col};
        sy = {r_oy[9], r_oy} + {{(11 - ROW_W){1'b0}}, r_row};

        // Column step of the coming row, worked out while the current row runs
        cdiff      = {r_right_nx[LIGHT_W-1], r_right_nx} - {r_left_nx[LIGHT_W-1], r_left_nx};
        cbias      = cdiff + (cdiff[LIGHT_W] ? (LIGHT_W + 1)'(BOX_WIDTH - 1) : '0);
        n_cstep_nx = LIGHT_W'(cbias >>> COL_SHIFT);

        left0  = LIGHT_W'(i_cmd.light_tl) <<< FIX_SHIFT;
        right0 = LIGHT_W'(i_cmd.light_tr) <<< FIX_SHIFT;

        n_left     = r_left;
        n_right    = r_right;
        n_left_nx  = r_left_nx;
        n_right_nx = r_right_nx;
        n_lstep    = r_lstep;
        n_rstep    = r_rstep;
        n_cstep    = r_cstep;
        n_run      = r_run;
        n_ox       = r_ox;
        n_oy       = r_oy;
        n_skip     = r_skip;
        n_done     = r_done;
        n_col      = r_col;
        n_row      = r_row;

        n_out_valid = i_pop ? 1'b0 : r_out_valid;
        n_out_pixel = r_out_pixel;
        n_screen_x  = r_screen_x;
        n_screen_y  = r_screen_y;
        n_we        = r_we;
        n_last      = r_last;

        if (take && is_start) begin
            n_ox       = i_cmd.box_x;
            n_oy       = i_cmd.box_y;
            n_skip     = i_cmd.transparent;
            n_left     = left0;
            n_right    = right0;
            n_lstep    = i_cmd.lstep;
            n_rstep    = i_cmd.rstep;
            n_left_nx  = left0 + i_cmd.lstep;
            n_right_nx = right0 + i_cmd.rstep;
            n_cstep    = i_cmd.cstep0;
            n_col      = '0;
            n_row      = '0;
            n_done     = 1'b0;
        end else if (take && produce) begin
            n_run = light + r_cstep;
            if (col_last) begin
                n_col      = '0;
                n_left     = r_left_nx;
                n_right    = r_right_nx;
                n_left_nx  = r_left_nx + r_lstep;
                n_right_nx = r_right_nx + r_rstep;
                n_cstep    = r_cstep_nx;
                if (r_row == ROW_W'(BOX_HEIGHT - 1)) begin
                    n_row  = '0;
                    n_done = 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end

            n_out_valid = 1'b1;
            n_out_pixel = {i_cmd.src[7:5], bright};
            n_screen_x  = 11'(sx);
            n_screen_y  = 10'(sy);
            n_we        = !sy[10] && (sy <= SY_LAST) && !sx[11] && (sx < SX_LIMIT)
                        && !(r_skip && (i_cmd.src == '0));
            n_last      = col_last && (r_row == ROW_W'(BOX_HEIGHT - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 1'b1;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_done      <= n_done;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left      <= n_left;
        r_right     <= n_right;
        r_left_nx   <= n_left_nx;
        r_right_nx  <= n_right_nx;
        r_lstep     <= n_lstep;
        r_rstep     <= n_rstep;
        r_cstep     <= n_cstep;
        r_cstep_nx  <= n_cstep_nx;
        r_run       <= n_run;
        r_ox        <= n_ox;
        r_oy        <= n_oy;
        r_skip      <= n_skip;
        r_out_pixel <= n_out_pixel;
        r_screen_x  <= n_screen_x;
        r_screen_y  <= n_screen_y;
        r_we        <= n_we;
        r_last      <= n_last;
    end

    assign o_cmd_take     = take;
    assign o_empty        = !r_out_valid;
    assign o_out_pixel    = r_out_pixel;
    assign o_screen_x     = r_screen_x;
    assign o_screen_y     = r_screen_y;
    assign o_write_enable = r_we;
    assign o_last_of_box  = r_last;
    assign o_status       = '{done: r_done, col: r_col, row: r_row};

endmodule

/* hw/rtl/gouraud_box_palette_shader.sv */
// A pixel transaction goes through the command queue into the result register. Throughput:
// one transaction per cycle, start or pixel, while the queue has room and a pixel finds the
// result register free or being popped; start transactions give no result.
// Reset (i_rst_n low at a rising edge, synchronous): empty the command queue, drop any
// waiting result and close the open box, so pixel transactions are dropped until a start.
module gouraud_box_palette_shader import gbps_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_operation,
    input  logic signed [10:0] i_box_x,
    input  logic signed [9:0]  i_box_y,
    input  logic signed [7:0]  i_light_top_left,
    input  logic signed [7:0]  i_light_top_right,
    input  logic signed [7:0]  i_light_bottom_left,
    input  logic signed [7:0]  i_light_bottom_right,
    input  logic               i_transparent,
    input  logic [7:0]         i_src_pixel,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_out_pixel,
    output logic signed [10:0] o_screen_x,
    output logic signed [9:0]  o_screen_y,
    output logic               o_write_enable,
    output logic               o_last_of_box
);

    // Front end to queue
    t_cmd         front_cmd;
    logic         q_wr;
    // Queue to back end
    t_cmd         q_head;
    logic         q_rd;
    logic         q_full;
    logic         q_empty;
    t_back_status bk_status;

    // Front: take each push while the queue has room and work out the per-box edge steps
    gbps_front u_front (
        .i_push               (push),
        .i_full               (q_full),
        .i_operation          (i_operation),
        .i_box_x              (i_box_x),
        .i_box_y              (i_box_y),
        .i_light_top_left     (i_light_top_left),
        .i_light_top_right    (i_light_top_right),
        .i_light_bottom_left  (i_light_bottom_left),
        .i_light_bottom_right (i_light_bottom_right),
        .i_transparent        (i_transparent),
        .i_src_pixel          (i_src_pixel),
        .o_wr                 (q_wr),
        .o_cmd                (front_cmd)
    );

    // Short queue so a stalled result side does not hold the input side at once
    gbps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (front_cmd),
        .i_rd    (q_rd),
        .o_data  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: walk the box, interpolate the light and shade each pixel into the result register
    gbps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!q_empty),
        .i_cmd          (q_head),
        .o_cmd_take     (q_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_pixel    (o_out_pixel),
        .o_screen_x     (o_screen_x),
        .o_screen_y     (o_screen_y),
        .o_write_enable (o_write_enable),
        .o_last_of_box  (o_last_of_box),
        .o_status       (bk_status)
    );

    assign full = q_full;

    // Never write into a full queue
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_wr)
        else $error("command written into full queue");

    // Never take from an empty queue
    a_no_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |-> !q_empty)
        else $error("command taken from empty queue");

    // With no box open the walk counters rest at the top left pixel
    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_status.done |-> (bk_status.col == '0 && bk_status.row == '0))
        else $error("box counters not at rest while no box is open");

    // A result carrying the last pixel of a box closes the box
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(!empty) && o_last_of_box) |-> bk_status.done)
        else $error("last pixel of box delivered while box still open");

endmodule
